// ===== sv/acwa_pkg.sv =====
// shared types and constants for the address cache with aging
package acwa_pkg;

    localparam logic [7:0] INVALID_ADDR = 8'd255;

    typedef enum logic [2:0] {
        ACT_LEARN    = 3'd0,
        ACT_LOOKUP   = 3'd1,
        ACT_RLOOKUP  = 3'd2,
        ACT_TICK     = 3'd3,
        ACT_MAINTAIN = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  node_address;
        logic [3:0]  port;
        logic [47:0] mac;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic        was_new;
        logic [7:0]  found_address;
        logic [3:0]  found_port;
        logic [47:0] found_mac;
        logic [6:0]  entry_count;
        logic [6:0]  removed_count;
        logic        broadcast_due;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch request, clear scan pointers
        logic scan;      // examine entry at read pointer
        logic finish;    // apply end-of-item updates, form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done; // search hit or pointer reached count
        logic no_scan;   // item needs no table walk
    } t_sts;

endpackage

// ===== sv/acwa_if.sv =====
// valid/ready channel interface
interface acwa_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/acwa_ctrl.sv =====
// sequencing state machine for the cache
module acwa_ctrl
    import acwa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = i_sts.no_scan ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== sv/acwa_dp.sv =====
// entry storage, scan pointers, time counters and result forming
module acwa_dp
    import acwa_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic [19:0] i_period,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_rsp        o_rsp
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // entry memory, one combined word per slot
    typedef struct packed {
        logic [7:0]  addr;
        logic [3:0]  port;
        logic [47:0] mac;
        logic [31:0] stamp;
    } t_entry;

    t_entry      r_mem [DEPTH];
    t_entry      r_rd;
    t_req        r_req;
    logic [CW-1:0] r_count, r_rp, r_wp, r_removed;
    logic        r_hit, r_rd_pending;
    logic [AW-1:0] r_hit_idx;
    logic [31:0] r_time, r_last_bc;

    logic [CW-1:0] w_rd_pos;
    logic          w_match, w_expired, w_rp_end, w_hit_now;
    logic [31:0]   w_age;
    logic [32:0]   w_limit;

    assign w_rp_end = (r_rp == r_count);
    assign w_age    = r_time - r_rd.stamp;
    assign w_limit  = {12'd0, i_period, 1'b0};
    assign w_expired = {1'b0, w_age} > w_limit;
    assign w_match  = (r_req.action == ACT_RLOOKUP) ? (r_rd.port == r_req.port)
                                                    : (r_rd.addr == r_req.node_address);
    assign w_rd_pos = r_rp - CW'(1);
    // search hit on the entry just read, keep it in the read register
    assign w_hit_now = r_rd_pending && (r_req.action != ACT_MAINTAIN) && w_match;

    // pipeline: address issued at r_rp, data registered in r_rd and checked in the next cycle
    assign o_sts.no_scan = !((r_req.action == ACT_LEARN &&
                              r_req.node_address != INVALID_ADDR) ||
                             r_req.action == ACT_LOOKUP ||
                             r_req.action == ACT_RLOOKUP ||
                             r_req.action == ACT_MAINTAIN);
    assign o_sts.scan_done = r_hit || (w_rp_end && !r_rd_pending);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && !w_rp_end && !w_hit_now) begin
            r_rd <= r_mem[r_rp[AW-1:0]];
        end
        if (i_cmd.scan && r_rd_pending && r_req.action == ACT_MAINTAIN && !w_expired) begin
            r_mem[r_wp[AW-1:0]] <= r_rd;
        end
        if (i_cmd.finish && r_req.action == ACT_LEARN &&
            r_req.node_address != INVALID_ADDR && (r_hit || r_count != CW'(DEPTH))) begin
            r_mem[r_hit ? r_hit_idx : r_count[AW-1:0]] <=
                '{addr: r_req.node_address, port: r_req.port, mac: r_req.mac, stamp: r_time};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.finish) begin
            o_rsp <= '0;
            o_rsp.found_address <= INVALID_ADDR;
            o_rsp.entry_count   <= 7'(r_count);
            case (r_req.action)
                ACT_LEARN: begin
                    if (r_req.node_address == INVALID_ADDR) begin
                        o_rsp.status <= ST_INVALID;
                    end else if (r_hit) begin
                        o_rsp.entry_index <= 6'(r_hit_idx);
                    end else if (r_count == CW'(DEPTH)) begin
                        o_rsp.status <= ST_FULL;
                    end else begin
                        o_rsp.entry_index <= 6'(r_count);
                        o_rsp.was_new     <= 1'b1;
                        o_rsp.entry_count <= 7'(r_count + CW'(1));
                    end
                end
                ACT_LOOKUP: begin
                    if (r_hit) begin
                        o_rsp.entry_index <= 6'(r_hit_idx);
                        o_rsp.found_port  <= r_rd.port;
                        o_rsp.found_mac   <= r_rd.mac;
                    end else begin
                        o_rsp.status <= ST_NOT_FOUND;
                    end
                end
                ACT_RLOOKUP: begin
                    if (r_hit) begin
                        o_rsp.entry_index   <= 6'(r_hit_idx);
                        o_rsp.found_address <= r_rd.addr;
                    end else begin
                        o_rsp.status <= ST_NOT_FOUND;
                    end
                end
                ACT_MAINTAIN: begin
                    o_rsp.entry_count   <= 7'(r_wp);
                    o_rsp.removed_count <= 7'(r_removed);
                    o_rsp.broadcast_due <= (r_time - r_last_bc) > {12'd0, i_period};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_time       <= '0;
            r_last_bc    <= '0;
            r_rp         <= '0;
            r_wp         <= '0;
            r_removed    <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_rd_pending <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rp         <= '0;
                r_wp         <= '0;
                r_removed    <= '0;
                r_hit        <= 1'b0;
                r_rd_pending <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (!w_rp_end) begin
                    r_rp <= r_rp + CW'(1);
                end
                r_rd_pending <= !w_rp_end;
                if (r_rd_pending) begin
                    if (r_req.action == ACT_MAINTAIN) begin
                        if (w_expired) begin
                            r_removed <= r_removed + CW'(1);
                        end else begin
                            r_wp <= r_wp + CW'(1);
                        end
                    end else if (w_match) begin
                        r_hit        <= 1'b1;
                        r_hit_idx    <= w_rd_pos[AW-1:0];
                        r_rp         <= r_rp;
                        r_rd_pending <= 1'b0;
                    end
                end
            end
            if (i_cmd.finish) begin
                case (r_req.action)
                    ACT_LEARN: begin
                        if (r_req.node_address != INVALID_ADDR && !r_hit &&
                            r_count != CW'(DEPTH)) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    ACT_TICK: r_time <= r_time + 32'd1;
                    ACT_MAINTAIN: begin
                        r_count <= r_wp;
                        if ((r_time - r_last_bc) > {12'd0, i_period}) begin
                            r_last_bc <= r_time;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== sv/address_cache_with_aging.sv =====
// Address cache with aging: a compacting table of up to DEPTH entries
// (node address, port, 48-bit MAC, last-learn time) and a millisecond
// counter advanced by tick items. Learn, lookup by address and reverse
// lookup by port walk the table from slot 0, one entry per cycle through
// a single registered memory read port, and stop at the lowest match;
// maintain walks all valid entries, dropping those older than twice
// update_period and copying survivors down in place. Tick, an unused
// action code or a learn of the invalid address do not walk the table.
// The result sits in an output register; the next item is taken the cycle
// after that result has been transferred.
module address_cache_with_aging
    import acwa_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acwa_if.sink        in_ch,
    acwa_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd        w_cmd;
    t_sts        w_sts;
    t_rsp        w_rsp;
    logic [19:0] r_period;
    logic        r_out_valid;
    logic        w_in_ready;

    // configuration register, single entry at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {12'd0, r_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 20'd1000;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_period <= pwdata[19:0];
        end
    end

    acwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_out_busy (r_out_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    acwa_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (in_ch.data),
        .i_period (r_period),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_rsp    (w_rsp)
    );

    assign in_ch.ready = w_in_ready;

    // result register is held until the transfer on the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = w_rsp;
endmodule

// ===== verif/tb_address_cache_with_aging.sv =====
// self-checking testbench for the address cache with aging
module tb_address_cache_with_aging;
    import acwa_pkg::*;

    localparam int DEPTH = 64;
    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic [1:0] REG_UPDATE_PERIOD = 2'd0;
    localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
    // longest item plus gaps and stalls; generous margin
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    acwa_if #(.T(t_req)) in_ch ();
    acwa_if #(.T(t_rsp)) out_ch ();

    address_cache_with_aging #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the cache contents
    logic [7:0]  shadow_addr [DEPTH];
    logic [3:0]  shadow_port [DEPTH];
    logic [47:0] shadow_mac [DEPTH];
    logic [31:0] shadow_stamp [DEPTH];
    int          shadow_count;
    logic [31:0] now_ms;
    logic [31:0] last_bcast;
    logic [19:0] update_period;

    t_req request_q[$];        // items waiting to be driven
    t_rsp expected_rsp_q[$];   // predicted results in order
    int   fail_count = 0;
    bit   calm = 1'b0;         // no gaps or stalls while set
    int   src_gap;
    int   sink_stall;
    int   quiet_cycles;

    function automatic int find_addr(logic [7:0] a);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic int find_port(logic [3:0] p);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_port[i] == p) return i;
        return -1;
    endfunction

    // advance the shadow cache by one item and form its result
    function automatic t_rsp cache_predict(t_req r);
        t_rsp o;
        int hit;
        int w;
        int slot;
        logic [31:0] age_limit;
        o = '0;
        o.found_address = INVALID_ADDR;
        case (r.action)
            ACT_LEARN: begin
                if (r.node_address == INVALID_ADDR) begin
                    o.status = ST_INVALID;
                end else begin
                    hit = find_addr(r.node_address);
                    if (hit < 0 && shadow_count >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        if (hit >= 0) begin
                            slot = hit;
                        end else begin
                            slot = shadow_count;
                            shadow_count++;
                            o.was_new = 1'b1;
                        end
                        shadow_addr[slot] = r.node_address;
                        shadow_port[slot] = r.port;
                        shadow_mac[slot] = r.mac;
                        shadow_stamp[slot] = now_ms;
                        o.entry_index = 6'(slot);
                    end
                end
            end
            ACT_LOOKUP: begin
                hit = find_addr(r.node_address);
                if (hit < 0) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    o.entry_index = 6'(hit);
                    o.found_port = shadow_port[hit];
                    o.found_mac = shadow_mac[hit];
                end
            end
            ACT_RLOOKUP: begin
                hit = find_port(r.port);
                if (hit < 0) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    o.entry_index = 6'(hit);
                    o.found_address = shadow_addr[hit];
                end
            end
            ACT_TICK: now_ms = now_ms + 32'd1;
            ACT_MAINTAIN: begin
                age_limit = 32'(update_period) * 32'd2;
                w = 0;
                for (int rd = 0; rd < shadow_count; rd++) begin
                    if (now_ms - shadow_stamp[rd] > age_limit) begin
                        o.removed_count++;
                    end else begin
                        shadow_addr[w] = shadow_addr[rd];
                        shadow_port[w] = shadow_port[rd];
                        shadow_mac[w] = shadow_mac[rd];
                        shadow_stamp[w] = shadow_stamp[rd];
                        w++;
                    end
                end
                shadow_count = w;
                if (now_ms - last_bcast > 32'(update_period)) begin
                    o.broadcast_due = 1'b1;
                    last_bcast = now_ms;
                end
            end
            default: ;
        endcase
        o.entry_count = 7'(shadow_count);
        return o;
    endfunction

    function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // driver: presents queued items with random gaps between transfers unless calm is set
    always @(posedge i_clk) begin
        int g;
        bit busy;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_rsp_q.push_back(cache_predict(in_ch.data));
                g = calm ? 0 : $urandom_range(0, 3);
                busy = 1'b0;
            end else begin
                g = src_gap;
                busy = in_ch.valid;
            end
            if (!busy) begin
                if (g > 0) begin
                    in_ch.valid <= 1'b0;
                    src_gap <= g - 1;
                end else if (request_q.size() > 0) begin
                    in_ch.data <= request_q.pop_front();
                    in_ch.valid <= 1'b1;
                    src_gap <= 0;
                end else begin
                    in_ch.valid <= 1'b0;
                    src_gap <= 0;
                end
            end
        end
    end

    // monitor: checks every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        int s;
        t_rsp exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    fail_count++;
                end else begin
                    exp_r = expected_rsp_q.pop_front();
                    check_field("status", exp_r.status, out_ch.data.status);
                    check_field("entry_index", exp_r.entry_index, out_ch.data.entry_index);
                    check_field("was_new", exp_r.was_new, out_ch.data.was_new);
                    check_field("found_address", exp_r.found_address,
                                out_ch.data.found_address);
                    check_field("found_port", exp_r.found_port, out_ch.data.found_port);
                    check_field("found_mac", exp_r.found_mac, out_ch.data.found_mac);
                    check_field("entry_count", exp_r.entry_count, out_ch.data.entry_count);
                    check_field("removed_count", exp_r.removed_count,
                                out_ch.data.removed_count);
                    check_field("broadcast_due", exp_r.broadcast_due,
                                out_ch.data.broadcast_due);
                end
                s = calm ? 0 : $urandom_range(0, 3);
            end else begin
                s = sink_stall;
            end
            if (s > 0) begin
                out_ch.ready <= 1'b0;
                sink_stall <= s - 1;
            end else begin
                out_ch.ready <= 1'b1;
                sink_stall <= 0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(logic [2:0] act, logic [7:0] a, logic [3:0] p, logic [47:0] m);
        t_req r;
        r.action = act;
        r.node_address = a;
        r.port = p;
        r.mac = m;
        request_q.push_back(r);
    endtask

    // hold off until every driven item has its result back
    task automatic drain();
        while (request_q.size() > 0 || in_ch.valid || expected_rsp_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // two-phase register write, shadow updated on the access cycle
    task automatic write_period(logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_UPDATE_PERIOD;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        update_period = v[19:0];
    endtask

    // mostly learns and lookups over a small address pool, ticks in bursts
    task automatic fill_random(int n, int addr_hi, int burst_hi);
        int k;
        int w;
        int b;
        logic [7:0] a;
        k = 0;
        while (k < n) begin
            w = $urandom_range(0, 99);
            a = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, addr_hi));
            if (w < 35) begin
                push_item(ACT_LEARN, a, 4'($urandom), 48'({$urandom, $urandom}));
                k++;
            end else if (w < 55) begin
                push_item(ACT_LOOKUP, a, 4'($urandom), 48'({$urandom, $urandom}));
                k++;
            end else if (w < 65) begin
                push_item(ACT_RLOOKUP, a, 4'($urandom), 48'({$urandom, $urandom}));
                k++;
            end else if (w < 83) begin
                b = $urandom_range(1, burst_hi);
                for (int j = 0; j < b; j++)
                    push_item(ACT_TICK, 8'($urandom), 4'($urandom), 48'({$urandom, $urandom}));
                k += b;
            end else if (w < 96) begin
                push_item(ACT_MAINTAIN, a, 4'($urandom), 48'({$urandom, $urandom}));
                k++;
            end else begin
                push_item(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), a,
                          4'($urandom), 48'({$urandom, $urandom}));
                k++;
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        shadow_count = 0;
        now_ms = '0;
        last_bcast = '0;
        update_period = 20'd1000;
        src_gap = 0;
        sink_stall = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, invalid address, extremes, duplicates, spare codes
        push_item(ACT_LEARN, INVALID_ADDR, 4'd3, 48'h1234);
        push_item(ACT_LOOKUP, 8'd0, 4'd0, '0);
        push_item(ACT_RLOOKUP, 8'd0, 4'd0, '0);
        push_item(ACT_MAINTAIN, 8'd0, 4'd0, '0);
        push_item(ACT_LEARN, 8'd0, 4'd0, '0);
        push_item(ACT_LEARN, 8'd254, 4'd15, MAC_ONES);
        push_item(ACT_LEARN, 8'd7, 4'd15, 48'hA5A5_5A5A_0F0F);
        push_item(ACT_RLOOKUP, 8'd0, 4'd15, '0);
        push_item(ACT_LOOKUP, 8'd254, 4'd0, '0);
        push_item(ACT_LEARN, 8'd0, 4'd9, 48'h8000_0000_0001);
        push_item(ACT_LOOKUP, 8'd0, 4'd0, '0);
        push_item(ACT_LOOKUP, INVALID_ADDR, 4'd0, '0);
        push_item(ACT_RLOOKUP, 8'd0, 4'd4, '0);
        for (logic [3:0] c = 4'(ACT_SPARE_FIRST); c <= 4'(ACT_SPARE_LAST); c++)
            push_item(c[2:0], 8'd7, 4'd15, MAC_ONES);
        push_item(ACT_TICK, 8'd0, 4'd0, '0);
        push_item(ACT_MAINTAIN, 8'd0, 4'd0, '0);
        push_item(ACT_LOOKUP, 8'd7, 4'd0, '0);
        drain();

        // zero period: anything older than the current tick expires
        write_period(32'd0);
        fill_random(300, 15, 3);
        drain();

        // short period with frequent ticks exercises aging and broadcasts
        write_period(32'd3);
        fill_random(250, 31, 6);
        drain();
        fill_random(250, 31, 6);
        drain();

        // longest period, wide addresses: table fills up
        write_period(32'h000F_FFFF);
        fill_random(250, 254, 4);
        drain();
        fill_random(250, 254, 4);
        drain();

        // period 1 without gaps or stalls
        calm = 1'b1;
        write_period(32'd1);
        fill_random(300, 40, 3);
        drain();
        calm = 1'b0;

        write_period(32'd20);
        fill_random(300, 63, 10);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/acwa_pkg.sv
sv/acwa_if.sv
sv/acwa_ctrl.sv
sv/acwa_dp.sv
sv/address_cache_with_aging.sv
verif/tb_address_cache_with_aging.sv
